[hdl/ldw_pkg.sv]
package ldw_pkg;

    localparam int CHAR_W             = 8;
    localparam int LEN_W              = 9;
    localparam int WINDOW_DEPTH_DEF   = 256;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_in;

    typedef struct packed {
        logic [LEN_W-1:0] best_length;
        logic [LEN_W-1:0] window_length;
        logic             done_res;
    } t_out;

endpackage

[hdl/longest_distinct_window_length_core.sv]
// Longest repeat-free window tracker. Returns one transaction per accepted byte, in the cycle
// after acceptance, carrying the current window length, the best length so far in the string
// and a copy of the last flag. Throughput is one byte per cycle unless o_stall is high, set by
// the row of WINDOW_DEPTH byte cells that all compare against the incoming byte in the same
// cycle, whose single hit is encoded into the next window length. State clears after last byte.
module longest_distinct_window_length_core
    import ldw_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int LW = $clog2(WINDOW_DEPTH + 1);

    logic [LW-1:0]     r_len;
    logic [LW-1:0]     r_best;
    logic              r_out_valid;
    t_out              r_out;

    logic [LW-1:0]     n_len;
    logic [LW-1:0]     n_best;

    logic              w_accept;
    logic [CHAR_W-1:0] w_cell_byte [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] w_hit;
    logic [LW-1:0]     w_hit_len;
    logic              w_any;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        logic [CHAR_W-1:0] w_prev;

        if (g == 0) begin : g_head
            assign w_prev = i_data.char_code;
        end else begin : g_body
            assign w_prev = w_cell_byte[g-1];
        end

        ldw_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_accept),
            .i_byte (w_prev),
            .i_key  (i_data.char_code),
            .i_live (LW'(g) < r_len),
            .o_byte (w_cell_byte[g]),
            .o_hit  (w_hit[g])
        );
    end

    ldw_enc #(
        .DEPTH(WINDOW_DEPTH)
    ) u_enc (
        .i_hit(w_hit),
        .o_len(w_hit_len),
        .o_any(w_any)
    );

    always_comb begin
        if (w_any) begin
            n_len = w_hit_len;
        end else if (r_len < LW'(WINDOW_DEPTH)) begin
            n_len = r_len + 1'b1;
        end else begin
            n_len = r_len;
        end
        n_best = (n_len > r_best) ? n_len : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_len       <= i_data.last ? '0 : n_len;
                r_best      <= i_data.last ? '0 : n_best;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.best_length   <= LEN_W'(n_best);
            r_out.window_length <= LEN_W'(n_len);
            r_out.done_res      <= i_data.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(WINDOW_DEPTH))
        else $error("window length beyond depth");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("window holds a repeated byte");

    a_best_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= r_best)
        else $error("best length below window length");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_data.last |=> r_len == '0 && r_best == '0)
        else $error("state not cleared after last byte");

    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.best_length >= o_data.window_length)
        else $error("reported best below window length");

endmodule

[hdl/ldw_cell.sv]
module ldw_cell
    import ldw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [CHAR_W-1:0] i_byte,
    input  logic [CHAR_W-1:0] i_key,
    input  logic              i_live,
    output logic [CHAR_W-1:0] o_byte,
    output logic              o_hit
);

    logic [CHAR_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = i_live && (r_byte == i_key);

endmodule

[hdl/ldw_enc.sv]
module ldw_enc
    import ldw_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic [DEPTH-1:0]               i_hit,
    output logic [$clog2(DEPTH+1)-1:0]     o_len,
    output logic                           o_any
);

    localparam int LW = $clog2(DEPTH + 1);

    always_comb begin
        o_len = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i_hit[i]) begin
                o_len = o_len | LW'(i + 1);
            end
        end
    end

    assign o_any = |i_hit;

endmodule
